### src/bsc_pkg.sv
// Package for the BSC secondary station responder: payload structs, line codes,
// response codes and the byte-wide reflected CRC-16 update. No dependencies.
package bsc_pkg;

    localparam int MaxFrame = 4096;
    localparam int CntW = $clog2(MaxFrame + 1);

    localparam logic [7:0] C_SYN = 8'h32;
    localparam logic [7:0] C_EOT = 8'h37;
    localparam logic [7:0] C_ENQ = 8'h2D;
    localparam logic [7:0] C_NAK = 8'h3D;
    localparam logic [7:0] C_DLE = 8'h10;
    localparam logic [7:0] C_STX = 8'h02;
    localparam logic [7:0] C_ETX = 8'h03;
    localparam logic [7:0] C_PAD = 8'hFF;
    localparam logic [7:0] C_ESC = 8'h27;
    localparam logic [7:0] C_ACK0 = 8'h70;
    localparam logic [7:0] C_ACK1 = 8'h61;
    localparam logic [7:0] C_GPOLL = 8'h7F;
    localparam logic [7:0] SEL_BIT = 8'h20;

    localparam logic [3:0] R_NONE = 4'd0;
    localparam logic [3:0] R_ACK0 = 4'd1;
    localparam logic [3:0] R_ACK1 = 4'd2;
    localparam logic [3:0] R_NAK = 4'd3;
    localparam logic [3:0] R_EOT = 4'd4;
    localparam logic [3:0] R_RVI = 4'd5;
    localparam logic [3:0] R_SENSE_NR = 4'd6;
    localparam logic [3:0] R_SENSE_DE = 4'd7;
    localparam logic [3:0] R_DATA = 4'd8;

    localparam logic [0:0] REG_CRC_POLY = 1'b0;
    localparam logic [15:0] CRC_POLY_RST = 16'hA001;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
        logic       terminal_connected;
        logic       terminal_has_data;
    } in_item_t;

    typedef struct packed {
        logic [3:0] response_code;
        logic       text_accepted;
        logic       crc_error;
        logic       skip_escape;
    } out_item_t;

    // Frame summary handed from front to back at frame end
    typedef struct packed {
        logic       lead_ok;
        logic       ack_match;
        logic       enq_match;
        logic       ps_frame;
        logic       gpoll;
        logic       select;
        logic       stx_match;
        logic       text_complete;
        logic       crc_good;
        logic       esc;
        logic       connected;
        logic       has_data;
    } frame_sum_t;

    // One byte of reflected CRC, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### src/bsc_front.sv
// Front end: stores header and tail bytes, runs the CRC, classifies at frame end.
// Depends on bsc_pkg.
module bsc_front
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] poly,
    input  logic        in_valid,
    input  in_item_t    in_data,
    output logic        in_stall,
    output logic        sum_valid,
    output frame_sum_t  sum_data,
    input  logic        sum_stall
);

    logic [7:0]      hdr_reg [8];
    logic [7:0]      tail_reg [4];
    logic [CntW-1:0] cnt_reg;
    logic [15:0]     crc_reg;
    logic            vld_reg;
    frame_sum_t      sum_reg;

    logic            take;
    logic            keep;
    logic [7:0]      hdr_n [8];
    logic [7:0]      tail_n [4];
    logic [CntW-1:0] cnt_next;
    logic [15:0]     crc_next;
    frame_sum_t      sum_next;

    assign in_stall = vld_reg && sum_stall;
    assign take = in_valid && !in_stall;
    assign keep = cnt_reg < CntW'(MaxFrame);
    assign sum_valid = vld_reg;
    assign sum_data = sum_reg;

    // Byte store and CRC for the kept bytes
    always_comb
    begin
        hdr_n = hdr_reg;
        tail_n = tail_reg;
        cnt_next = cnt_reg;
        crc_next = crc_reg;
        if (keep)
        begin
            if (cnt_reg >= CntW'(6))
                crc_next = crc_byte(crc_reg, tail_reg[2], poly);
            if (cnt_reg < CntW'(8))
                hdr_n[cnt_reg[2:0]] = in_data.rx_byte;
            tail_n[3] = tail_reg[2];
            tail_n[2] = tail_reg[1];
            tail_n[1] = tail_reg[0];
            tail_n[0] = in_data.rx_byte;
            cnt_next = cnt_reg + CntW'(1);
        end
    end

    // Classification on the updated frame
    always_comb
    begin
        sum_next.lead_ok = cnt_next >= CntW'(2) && hdr_n[0] == C_SYN && hdr_n[1] == C_SYN;
        sum_next.ack_match = cnt_next >= CntW'(5) && hdr_n[2] == C_DLE &&
            (hdr_n[3] == C_ACK0 || hdr_n[3] == C_ACK1) && hdr_n[4] == C_PAD;
        sum_next.enq_match = cnt_next >= CntW'(4) && hdr_n[2] == C_ENQ && hdr_n[3] == C_PAD;
        sum_next.ps_frame = cnt_next == CntW'(8) && hdr_n[6] == C_ENQ;
        sum_next.gpoll = hdr_n[4] == C_GPOLL && hdr_n[5] == C_GPOLL;
        sum_next.select = (hdr_n[2] & SEL_BIT) != 8'h00;
        sum_next.stx_match = cnt_next >= CntW'(3) && hdr_n[2] == C_STX;
        sum_next.text_complete = cnt_next >= CntW'(7) && tail_n[0] == C_PAD &&
            tail_n[3] == C_ETX;
        sum_next.crc_good = crc_next[7:0] == tail_n[2] && crc_next[15:8] == tail_n[1];
        sum_next.esc = hdr_n[3] == C_ESC;
        sum_next.connected = in_data.terminal_connected;
        sum_next.has_data = in_data.terminal_has_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            crc_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cnt_reg <= in_data.frame_end ? '0 : cnt_next;
                crc_reg <= in_data.frame_end ? '0 : crc_next;
            end
            if (take && in_data.frame_end)
                vld_reg <= 1'b1;
            else if (!sum_stall)
                vld_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hdr_reg <= hdr_n;
            tail_reg <= tail_n;
            if (in_data.frame_end)
                sum_reg <= sum_next;
        end
    end

endmodule

### src/bsc_queue.sv
// Two-entry queue between front and back ends carrying frame summaries.
// Depends on bsc_pkg.
module bsc_queue
    import bsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    input  frame_sum_t wr_data,
    output logic       wr_stall,
    output logic       rd_valid,
    output frame_sum_t rd_data,
    input  logic       rd_stall
);

    frame_sum_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_stall = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign push = wr_valid && !wr_stall;
    assign pop = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

### src/bsc_back.sv
// Back end: applies station state to a frame summary and registers the response.
// Depends on bsc_pkg.
module bsc_back
    import bsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sum_valid,
    input  frame_sum_t sum_data,
    output logic       sum_stall,
    output logic       out_valid,
    output out_item_t  out_data,
    input  logic       out_stall
);

    logic      ack0_reg, eotp_reg, nr_reg, vld_reg;
    out_item_t out_reg;
    logic      ack0_next, eotp_next, nr_next;
    out_item_t out_next;
    logic      take, ack_req, nak_req;

    assign sum_stall = vld_reg && out_stall;
    assign take = sum_valid && !sum_stall;
    assign out_valid = vld_reg;
    assign out_data = out_reg;

    // Response resolution, later matches override earlier ones
    always_comb
    begin
        ack0_next = ack0_reg;
        eotp_next = eotp_reg;
        nr_next = nr_reg;
        out_next = '0;
        ack_req = 1'b0;
        nak_req = 1'b0;
        if (sum_data.lead_ok)
        begin
            if (sum_data.ack_match && eotp_reg)
            begin
                out_next.response_code = R_EOT;
                eotp_next = 1'b0;
            end
            if (sum_data.enq_match)
            begin
                ack0_next = 1'b1;
                ack_req = 1'b1;
            end
            if (sum_data.ps_frame)
            begin
                if (sum_data.gpoll)
                begin
                    if (!sum_data.connected)
                        out_next.response_code = R_EOT;
                    else if (nr_reg)
                    begin
                        out_next.response_code = R_SENSE_DE;
                        eotp_next = 1'b1;
                        nr_next = 1'b0;
                    end
                    else if (sum_data.has_data)
                    begin
                        out_next.response_code = R_DATA;
                        eotp_next = 1'b1;
                    end
                    else
                        out_next.response_code = R_EOT;
                end
                else if (sum_data.select)
                begin
                    if (sum_data.connected)
                    begin
                        ack0_next = 1'b1;
                        ack_req = 1'b1;
                    end
                    else
                        out_next.response_code = R_RVI;
                end
                else if (sum_data.connected)
                    ack_req = 1'b1;
                else
                begin
                    out_next.response_code = R_SENSE_NR;
                    eotp_next = 1'b1;
                    nr_next = 1'b1;
                end
            end
            if (sum_data.stx_match)
            begin
                if (sum_data.text_complete && sum_data.crc_good)
                begin
                    out_next.text_accepted = 1'b1;
                    out_next.skip_escape = sum_data.esc;
                    ack_req = 1'b1;
                end
                else
                begin
                    out_next.crc_error = sum_data.text_complete;
                    nak_req = 1'b1;
                end
            end
            if (ack_req)
            begin
                out_next.response_code = ack0_next ? R_ACK0 : R_ACK1;
                ack0_next = !ack0_next;
            end
            if (nak_req)
                out_next.response_code = R_NAK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack0_reg <= 1'b1;
            eotp_reg <= 1'b0;
            nr_reg <= 1'b1;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ack0_reg <= ack0_next;
                eotp_reg <= eotp_next;
                nr_reg <= nr_next;
                vld_reg <= 1'b1;
            end
            else if (!out_stall)
                vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

endmodule

### src/bsc_secondary_station_responder.sv
// BSC secondary station responder, top level: APB register, front, queue, back.
// Depends on bsc_pkg, bsc_front, bsc_queue, bsc_back.
// One byte per cycle when not stalled; the byte-wide CRC update in the front end
// sets that rate. After a frame's last byte is taken its response passes the front
// register, queue entry and back register; queue holds two frame summaries.
// Reset: station state set, counters and CRC cleared, poly A001 hex, no data held.
module bsc_secondary_station_responder
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  in_item_t    in_data,
    output logic        in_stall,
    output logic        out_valid,
    output out_item_t   out_data,
    input  logic        out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] poly_reg;
    logic        f_valid, f_stall, b_valid, b_stall;
    frame_sum_t  f_data, b_data;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == {REG_CRC_POLY, 1'b0}) ? {16'h0000, poly_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poly_reg <= CRC_POLY_RST;
        else if (psel && penable && pwrite && paddr == {REG_CRC_POLY, 1'b0})
            poly_reg <= pwdata[15:0];
    end

    bsc_front u_front (
        .clk(clk), .rst_n(rst_n), .poly(poly_reg),
        .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
        .sum_valid(f_valid), .sum_data(f_data), .sum_stall(f_stall)
    );

    bsc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_data(f_data), .wr_stall(f_stall),
        .rd_valid(b_valid), .rd_data(b_data), .rd_stall(b_stall)
    );

    bsc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .sum_valid(b_valid), .sum_data(b_data), .sum_stall(b_stall),
        .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
    );

endmodule

### src/bsc_checker.sv
// Port-level checker for the BSC responder, bound to the top level.
// Depends on bsc_pkg.
module bsc_checker
    import bsc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input in_item_t  in_data,
    input logic      in_stall,
    input logic      out_valid,
    input out_item_t out_data,
    input logic      out_stall
);

    // A stalled input transfer holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input changed");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Pass and fail flags never together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.text_accepted && out_data.crc_error))
        else $error("text accepted and crc error together");

    // Accepted text is always acknowledged
    a_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.text_accepted |->
        (out_data.response_code == R_ACK0 || out_data.response_code == R_ACK1))
        else $error("accepted text not acked");

    // A CRC failure answers NAK
    a_nak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.crc_error |-> out_data.response_code == R_NAK)
        else $error("crc error not answered with NAK");

endmodule

bind bsc_secondary_station_responder bsc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_data(in_data),
    .in_stall(in_stall), .out_valid(out_valid), .out_data(out_data),
    .out_stall(out_stall)
);

### verif/bsc_secondary_station_responder_tb.sv
// Testbench for bsc_secondary_station_responder: directed frames, then random frames
// checked against an in-bench model of the station. Depends on bsc_pkg and the RTL.
module bsc_secondary_station_responder_tb;
    import bsc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    in_item_t    in_data;
    logic        in_stall;
    logic        out_valid;
    out_item_t   out_data;
    logic        out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bsc_secondary_station_responder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
        .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // station model state
    logic [15:0] poly;
    logic        ack_even;
    logic        eot_owed;
    logic        term_nr;
    logic [7:0]  hdr [8];
    int          nbytes;
    logic [7:0]  tail [4];
    logic [15:0] crc_acc;

    out_item_t   resp_q [$];
    int          errs;
    int          frames_sent;
    int          bytes_sent;
    int          resp_checked;
    bit          calm;
    int          hold_req;
    int          quiet_cycles;

    // directed stimulus rows; chk marks a typed-in response code
    typedef struct {
        logic [7:0] b;
        bit         e;
        bit         c;
        bit         d;
        bit         chk;
        logic [3:0] code;
    } row_t;

    row_t rows [27] = '{
        '{8'h00, 1, 0, 0, 1, R_NONE},
        '{8'hFF, 1, 1, 1, 1, R_NONE},
        '{C_SYN, 0, 1, 0, 0, R_NONE}, '{C_SYN, 0, 0, 1, 0, R_NONE},
        '{C_ENQ, 0, 1, 0, 0, R_NONE}, '{C_PAD, 1, 0, 0, 1, R_ACK0},
        '{C_SYN, 0, 0, 0, 0, R_NONE}, '{C_SYN, 0, 0, 0, 0, R_NONE},
        '{C_EOT, 0, 0, 0, 0, R_NONE}, '{C_PAD, 1, 1, 0, 1, R_NONE},
        '{C_SYN, 0, 0, 0, 0, R_NONE}, '{C_SYN, 0, 0, 0, 0, R_NONE},
        '{C_NAK, 0, 0, 0, 0, R_NONE}, '{C_PAD, 1, 0, 1, 1, R_NONE},
        '{C_SYN, 0, 1, 1, 0, R_NONE}, '{C_SYN, 0, 1, 1, 0, R_NONE},
        '{8'h40, 0, 1, 1, 0, R_NONE}, '{8'h40, 0, 1, 1, 0, R_NONE},
        '{C_GPOLL, 0, 1, 1, 0, R_NONE}, '{C_GPOLL, 0, 1, 1, 0, R_NONE},
        '{C_ENQ, 0, 1, 1, 0, R_NONE}, '{C_PAD, 1, 1, 1, 1, R_SENSE_DE},
        '{C_SYN, 0, 0, 0, 0, R_NONE}, '{C_SYN, 0, 0, 0, 0, R_NONE},
        '{C_DLE, 0, 0, 0, 0, R_NONE}, '{C_ACK0, 0, 0, 0, 0, R_NONE},
        '{C_PAD, 1, 0, 0, 1, R_EOT}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // reflected CRC-16, one byte
    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b,
                                             logic [15:0] p);
        c = c ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ p) : (c >> 1);
        return c;
    endfunction

    function automatic bit head_has(int n, logic [7:0] p0, logic [7:0] p1,
                                    logic [7:0] p2, logic [7:0] p3,
                                    logic [7:0] p4);
        logic [7:0] p [5];
        p = '{p0, p1, p2, p3, p4};
        if (nbytes < n)
            return 0;
        for (int i = 0; i < n; i++)
            if (hdr[i] !== p[i])
                return 0;
        return 1;
    endfunction

    // station model: take one byte, return the response at frame end
    task automatic station_step(input in_item_t it, output bit has, output out_item_t r);
        bit ack_req;
        bit nak_req;
        bit gpoll;
        bit sel;
        r = '0;
        has = 0;
        ack_req = 0;
        nak_req = 0;
        if (nbytes < MaxFrame)
        begin
            if (nbytes >= 6)
                crc_acc = crc_next(crc_acc, tail[2], poly);
            if (nbytes < 8)
                hdr[nbytes] = it.rx_byte;
            tail[3] = tail[2];
            tail[2] = tail[1];
            tail[1] = tail[0];
            tail[0] = it.rx_byte;
            nbytes++;
        end
        if (!it.frame_end)
            return;
        has = 1;
        if (nbytes >= 2 && hdr[0] == C_SYN && hdr[1] == C_SYN)
        begin
            if ((head_has(5, C_SYN, C_SYN, C_DLE, C_ACK0, C_PAD) ||
                 head_has(5, C_SYN, C_SYN, C_DLE, C_ACK1, C_PAD)) && eot_owed)
            begin
                r.response_code = R_EOT;
                eot_owed = 0;
            end
            if (head_has(4, C_SYN, C_SYN, C_ENQ, C_PAD, 8'h00))
            begin
                ack_even = 1;
                ack_req = 1;
            end
            if (nbytes == 8 && hdr[6] == C_ENQ)
            begin
                gpoll = hdr[4] == C_GPOLL && hdr[5] == C_GPOLL;
                sel = (hdr[2] & SEL_BIT) != 0;
                if (gpoll)
                begin
                    if (it.terminal_connected)
                    begin
                        if (it.terminal_has_data && !term_nr)
                        begin
                            r.response_code = R_DATA;
                            eot_owed = 1;
                        end
                        else
                            r.response_code = R_EOT;
                        if (term_nr)
                        begin
                            r.response_code = R_SENSE_DE;
                            eot_owed = 1;
                            term_nr = 0;
                        end
                    end
                    else
                        r.response_code = R_EOT;
                end
                else if (sel)
                begin
                    if (it.terminal_connected)
                    begin
                        ack_even = 1;
                        ack_req = 1;
                    end
                    else
                        r.response_code = R_RVI;
                end
                else if (it.terminal_connected)
                    ack_req = 1;
                else
                begin
                    r.response_code = R_SENSE_NR;
                    eot_owed = 1;
                    term_nr = 1;
                end
            end
            if (head_has(3, C_SYN, C_SYN, C_STX, 8'h00, 8'h00))
            begin
                if (nbytes >= 7 && tail[0] == C_PAD && tail[3] == C_ETX)
                begin
                    if (crc_acc[7:0] == tail[2] && crc_acc[15:8] == tail[1])
                    begin
                        r.text_accepted = 1;
                        r.skip_escape = hdr[3] == C_ESC;
                        ack_req = 1;
                    end
                    else
                    begin
                        r.crc_error = 1;
                        nak_req = 1;
                    end
                end
                else
                    nak_req = 1;
            end
            if (ack_req)
            begin
                r.response_code = ack_even ? R_ACK0 : R_ACK1;
                ack_even = !ack_even;
            end
            if (nak_req)
                r.response_code = R_NAK;
        end
        nbytes = 0;
        crc_acc = '0;
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errs++;
    endtask

    // one transfer on the input channel; typed code replaces the model's when given
    task automatic send_byte(input in_item_t it, input bit chk, input logic [3:0] code);
        bit has;
        out_item_t r;
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        station_step(it, has, r);
        bytes_sent++;
        if (has)
        begin
            if (chk)
                r = '{code, 1'b0, 1'b0, 1'b0};
            resp_q.push_back(r);
            frames_sent++;
        end
    endtask

    task automatic send_frame(input logic [7:0] fb [$]);
        in_item_t it;
        foreach (fb[i])
        begin
            it.rx_byte = fb[i];
            it.frame_end = (i == fb.size() - 1);
            it.terminal_connected = $urandom_range(3) != 0;
            it.terminal_has_data = 1'($urandom_range(1));
            send_byte(it, 0, R_NONE);
        end
    endtask

    // wait until every response is back, then let the pipeline empty
    task automatic drain();
        in_valid <= 1'b0;
        while (resp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_poly(input logic [15:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_CRC_POLY, 1'b0} << 1;
        pwdata <= {16'h0000, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        poly = v;
    endtask

    // build one random frame of a random kind
    task automatic make_frame(output logic [7:0] fb [$]);
        logic [15:0] c;
        int kind;
        int n;
        fb = {};
        kind = $urandom_range(11);
        case (kind)
            0, 1, 2, 3:
            begin
                // text: good, bad check, incomplete, escape lead
                fb = {C_SYN, C_SYN, C_STX};
                if (kind == 3 || $urandom_range(5) == 0)
                    fb.push_back(C_ESC);
                n = $urandom_range(8);
                repeat (n) fb.push_back(8'($urandom_range(255)));
                fb.push_back(C_ETX);
                c = '0;
                for (int i = 3; i < fb.size(); i++)
                    c = crc_next(c, fb[i], poly);
                if (kind == 1)
                    c ^= 16'h1 << $urandom_range(15);
                fb.push_back(c[7:0]);
                fb.push_back(c[15:8]);
                fb.push_back(C_PAD);
                if (kind == 2)
                    repeat ($urandom_range(1, 4)) void'(fb.pop_back());
            end
            4, 5, 6:
            begin
                // general poll, select, specific poll
                fb = {C_SYN, C_SYN, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)), C_ENQ, C_PAD};
                if (kind == 4)
                begin
                    fb[4] = C_GPOLL;
                    fb[5] = C_GPOLL;
                end
                else if (kind == 5)
                    fb[2] |= SEL_BIT;
                else
                    fb[2] &= ~SEL_BIT;
            end
            7:
                fb = {C_SYN, C_SYN, C_ENQ, C_PAD};
            8:
                fb = {C_SYN, C_SYN, C_DLE, $urandom_range(1) ? C_ACK0 : C_ACK1, C_PAD};
            9:
                fb = {C_SYN, C_SYN, $urandom_range(1) ? C_EOT : C_NAK, C_PAD};
            default:
            begin
                // line noise, sometimes with a lead-in
                n = $urandom_range(1, 10);
                repeat (n) fb.push_back(8'($urandom_range(255)));
                if ($urandom_range(1))
                    fb[0] = C_SYN;
                if (fb.size() > 1 && $urandom_range(1))
                    fb[1] = C_SYN;
            end
        endcase
        // short frames cut from any pattern
        if ($urandom_range(15) == 0 && fb.size() > 1)
            repeat ($urandom_range(1, fb.size() - 1)) void'(fb.pop_back());
    endtask

    // result channel: check each transfer, drive stall
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (resp_q.size() == 0)
                report("unexpected transfer", out_data.response_code, -1);
            else
            begin
                want = resp_q.pop_front();
                resp_checked++;
                if (out_data.response_code !== want.response_code)
                    report("response_code", out_data.response_code, want.response_code);
                if (out_data.text_accepted !== want.text_accepted)
                    report("text_accepted", out_data.text_accepted, want.text_accepted);
                if (out_data.crc_error !== want.crc_error)
                    report("crc_error", out_data.crc_error, want.crc_error);
                if (out_data.skip_escape !== want.skip_escape)
                    report("skip_escape", out_data.skip_escape, want.skip_escape);
            end
        end
        if (hold_req > 0)
        begin
            out_stall <= 1'b1;
            hold_req <= hold_req - 1;
        end
        else
            out_stall <= !calm && $urandom_range(99) < 35;
    end

    // watchdog on transfer activity
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == 3000)
        begin
            $display("watchdog expired with %0d responses outstanding", resp_q.size());
            $display("bsc_secondary_station_responder_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] fb [$];
        logic [15:0] polys [5];
        in_item_t it;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errs = 0;
        frames_sent = 0;
        bytes_sent = 0;
        resp_checked = 0;
        calm = 0;
        hold_req = 0;
        quiet_cycles = 0;
        poly = CRC_POLY_RST;
        ack_even = 1;
        eot_owed = 0;
        term_nr = 1;
        nbytes = 0;
        crc_acc = '0;
        foreach (hdr[i]) hdr[i] = '0;
        foreach (tail[i]) tail[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames from reset
        foreach (rows[i])
        begin
            it = '{rows[i].b, rows[i].e, rows[i].c, rows[i].d};
            send_byte(it, rows[i].chk, rows[i].code);
        end
        drain();

        polys = '{16'h0000, 16'hFFFF, 16'($urandom_range(65535)), 16'h8408, CRC_POLY_RST};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_poly(polys[ph]);
            calm = (ph == 2);
            if (ph == 1)
                hold_req = 400;
            repeat (23)
            begin
                make_frame(fb);
                send_frame(fb);
            end
            // polynomial changes only with nothing in flight
            drain();
        end

        $display("%0d bytes in %0d frames sent, %0d responses checked, five CRC polynomials",
                 bytes_sent, frames_sent, resp_checked);
        $display("covered polls, selects, ENQ, ACK, text good/bad/short, line noise");
        if (errs == 0)
            $display("bsc_secondary_station_responder_tb OK");
        else
            $display("bsc_secondary_station_responder_tb NOT OK");
        $finish;
    end

endmodule
